FILE: design/rieu_pkg.sv
// Shared types and constants for the integer execute unit.
// No dependencies; the ALU, MAC and top-level design files import this package.
`default_nettype none
package rieu_pkg;

	localparam int NUM_REGS  = 16;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int XLEN      = 32;

	localparam logic [XLEN-1:0] SEXT8_MASK  = 32'hFFFF_FF00;
	localparam logic [XLEN-1:0] SIGN_BIT    = 32'h8000_0000;
	localparam logic [XLEN-1:0] HALF_SIGN   = 32'h0000_8000;
	localparam logic [XLEN-1:0] SEXT16_MASK = 32'hFFFF_0000;
	localparam logic [7:0]      BYTE_SIGN   = 8'h80;

	localparam logic [1:0] CYC_ONE   = 2'd1;
	localparam logic [1:0] CYC_MUL   = 2'd2;
	localparam logic [1:0] CYC_TAKEN = 2'd3;

	typedef enum logic [4:0] {
		CMD_NOP    = 5'd0,  CMD_ADD    = 5'd1,  CMD_ADDI   = 5'd2,  CMD_ADDC  = 5'd3,
		CMD_ADDV   = 5'd4,  CMD_AND    = 5'd5,  CMD_ANDI   = 5'd6,  CMD_BF    = 5'd7,
		CMD_BT     = 5'd8,  CMD_CLRMAC = 5'd9,  CMD_CLRT   = 5'd10, CMD_CMPEQ = 5'd11,
		CMD_CMPGE  = 5'd12, CMD_CMPGT  = 5'd13, CMD_CMPHI  = 5'd14, CMD_CMPHS = 5'd15,
		CMD_CMPPL  = 5'd16, CMD_CMPPZ  = 5'd17, CMD_CMPSTR = 5'd18, CMD_CMPEQI = 5'd19,
		CMD_DIV0S  = 5'd20, CMD_DIV0U  = 5'd21, CMD_DIV1   = 5'd22, CMD_DMULS = 5'd23,
		CMD_DMULU  = 5'd24, CMD_DT     = 5'd25, CMD_EXTSB  = 5'd26, CMD_EXTSW = 5'd27,
		CMD_EXTUB  = 5'd28, CMD_EXTUW  = 5'd29
	} cmd_t;

	typedef struct packed {
		logic            wr_en;
		logic [XLEN-1:0] wr_data;
		logic            t;
		logic            q;
		logic            m;
		logic [XLEN-1:0] pc_next;
		logic [1:0]      cycles;
		logic            mul_en;
		logic            mul_signed;
		logic            clr_mac;
	} alu_res_t;

	typedef struct packed {
		logic            mul_en;
		logic            mul_signed;
		logic            clr_mac;
	} mac_ctl_t;

	function automatic logic [XLEN-1:0] sext8(input logic [7:0] v);
		return v[7] ? ({24'd0, v} | SEXT8_MASK) : {24'd0, v};
	endfunction

endpackage
`default_nettype wire

FILE: design/rieu_ram.sv
// Generic synchronous RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module rieu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: design/rieu_alu.sv
// Execute-stage datapath: computes register, flag, PC and multiply results.
// Depends on rieu_pkg.
`default_nettype none
module rieu_alu (
	input  wire                        [4:0] cmd,
	input  wire                        [7:0] imm,
	input  wire  [rieu_pkg::XLEN-1:0]        rn,
	input  wire  [rieu_pkg::XLEN-1:0]        rm,
	input  wire                              t_in,
	input  wire                              q_in,
	input  wire                              m_in,
	input  wire  [rieu_pkg::XLEN-1:0]        pc,
	output rieu_pkg::alu_res_t               res,
	output logic [2*rieu_pkg::XLEN-1:0]      prod
);
	import rieu_pkg::*;

	logic [XLEN:0]   sum33;
	logic [XLEN-1:0] xr;
	logic [XLEN-1:0] dsh;
	logic [XLEN:0]   dres;
	logic            dcarry;
	logic            dq;
	logic [XLEN-1:0] dec;
	logic            taken;
	logic [XLEN-1:0] simm;

	always_comb begin
		prod  = {{XLEN{1'b0}}, rn} * {{XLEN{1'b0}}, rm};
		xr    = rn ^ rm;
		dsh   = {rn[XLEN-2:0], t_in};
		dres  = (q_in == m_in) ? ({1'b0, dsh} - {1'b0, rm}) : ({1'b0, dsh} + {1'b0, rm});
		dcarry = dres[XLEN];
		dq    = rn[XLEN-1] ^ dcarry ^ m_in;
		dec   = rn - 32'd1;
		sum33 = {1'b0, rn} + {1'b0, rm};
		simm  = sext8(imm);
		taken = 1'b0;

		res            = '0;
		res.t          = t_in;
		res.q          = q_in;
		res.m          = m_in;
		res.pc_next    = pc + 32'd2;
		res.cycles     = CYC_ONE;

		unique case (cmd)
			CMD_ADD: begin
				res.wr_en = 1'b1; res.wr_data = sum33[XLEN-1:0];
			end
			CMD_ADDI: begin
				res.wr_en = 1'b1; res.wr_data = rn + simm;
			end
			CMD_ADDC: begin
				sum33 = {1'b0, rn} + {1'b0, rm} + {{XLEN{1'b0}}, t_in};
				res.wr_en = 1'b1; res.wr_data = sum33[XLEN-1:0]; res.t = sum33[XLEN];
			end
			CMD_ADDV: begin
				res.wr_en = 1'b1; res.wr_data = sum33[XLEN-1:0];
				res.t = ~(rn[XLEN-1] ^ rm[XLEN-1]) & (rn[XLEN-1] ^ sum33[XLEN-1]);
			end
			CMD_AND: begin
				res.wr_en = 1'b1; res.wr_data = rn & rm;
			end
			CMD_ANDI: begin
				res.wr_en = 1'b1; res.wr_data = rn & {24'd0, imm};
			end
			CMD_BF, CMD_BT: begin
				taken = (t_in == (cmd == CMD_BT));
				if (taken) begin
					res.pc_next = pc + 32'd4 + {simm[XLEN-2:0], 1'b0};
					res.cycles  = CYC_TAKEN;
				end
			end
			CMD_CLRMAC: res.clr_mac = 1'b1;
			CMD_CLRT:   res.t = 1'b0;
			CMD_CMPEQ:  res.t = (rn == rm);
			CMD_CMPGE:  res.t = ((rn ^ SIGN_BIT) >= (rm ^ SIGN_BIT));
			CMD_CMPGT:  res.t = ((rn ^ SIGN_BIT) > (rm ^ SIGN_BIT));
			CMD_CMPHI:  res.t = (rn > rm);
			CMD_CMPHS:  res.t = (rn >= rm);
			CMD_CMPPL:  res.t = (rn != '0) && !rn[XLEN-1];
			CMD_CMPPZ:  res.t = !rn[XLEN-1];
			CMD_CMPSTR: res.t = (xr[31:24] == 8'd0) || (xr[23:16] == 8'd0) ||
				(xr[15:8] == 8'd0) || (xr[7:0] == 8'd0);
			CMD_CMPEQI: res.t = (rn == simm);
			CMD_DIV0S: begin
				res.q = rn[XLEN-1]; res.m = rm[XLEN-1]; res.t = rn[XLEN-1] ^ rm[XLEN-1];
			end
			CMD_DIV0U: begin
				res.q = 1'b0; res.m = 1'b0; res.t = 1'b0;
			end
			CMD_DIV1: begin
				res.wr_en = 1'b1; res.wr_data = dres[XLEN-1:0];
				res.q = dq; res.t = (dq == m_in);
			end
			CMD_DMULS: begin
				res.mul_en = 1'b1; res.mul_signed = 1'b1; res.cycles = CYC_MUL;
			end
			CMD_DMULU: begin
				res.mul_en = 1'b1; res.cycles = CYC_MUL;
			end
			CMD_DT: begin
				res.wr_en = 1'b1; res.wr_data = dec; res.t = (dec == '0);
			end
			CMD_EXTSB: begin
				res.wr_en = 1'b1;
				res.wr_data = rm[7] ? ({24'd0, rm[7:0]} | SEXT8_MASK) : {24'd0, rm[7:0]};
			end
			CMD_EXTSW: begin
				res.wr_en = 1'b1;
				res.wr_data = ((rm & HALF_SIGN) != '0) ? ({16'd0, rm[15:0]} | SEXT16_MASK)
					: {16'd0, rm[15:0]};
			end
			CMD_EXTUB: begin
				res.wr_en = 1'b1; res.wr_data = {24'd0, rm[7:0]};
			end
			CMD_EXTUW: begin
				res.wr_en = 1'b1; res.wr_data = {16'd0, rm[15:0]};
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: design/rieu_mac.sv
// MAC pair update: load of the registered product, with signed correction for signed multiplies, or clear.
// Depends on rieu_pkg.
`default_nettype none
module rieu_mac (
	input  wire rieu_pkg::mac_ctl_t        ctl,
	input  wire [2*rieu_pkg::XLEN-1:0]     prod,
	input  wire [rieu_pkg::XLEN-1:0]       rn,
	input  wire [rieu_pkg::XLEN-1:0]       rm,
	input  wire [rieu_pkg::XLEN-1:0]       mach,
	input  wire [rieu_pkg::XLEN-1:0]       macl,
	output logic [rieu_pkg::XLEN-1:0]      mach_next,
	output logic [rieu_pkg::XLEN-1:0]      macl_next
);
	import rieu_pkg::*;

	logic [XLEN-1:0] hi;

	always_comb begin
		hi = prod[2*XLEN-1:XLEN];
		if (ctl.mul_signed && rn[XLEN-1]) begin
			hi = hi - rm;
		end
		if (ctl.mul_signed && rm[XLEN-1]) begin
			hi = hi - rn;
		end
		mach_next = mach;
		macl_next = macl;
		if (ctl.clr_mac) begin
			mach_next = '0;
			macl_next = '0;
		end else if (ctl.mul_en) begin
			mach_next = hi;
			macl_next = prod[XLEN-1:0];
		end
	end
endmodule
`default_nettype wire

FILE: design/risc_integer_execute_unit.sv
// Top level of the integer execute unit: register file RAMs, execute and MAC stages.
// Depends on rieu_pkg, rieu_ram, rieu_alu and rieu_mac.
//
// Usage: each request on the s_axis channel is one instruction, packed in
// s_axis_tdata as cmd, dest_index, src_index and imm8 from the lowest bit up.
// Each request yields exactly one result on m_axis: the new Rn (or R0 for the AND
// and compare immediate forms), T, the next PC, MACH, MACL and instruction cycle count.
// The block takes one request per cycle while s_axis_tready is high. The register
// file read is issued at the accepting edge; the request then passes through the
// execute stage (where the 32x32 product is formed) and the MAC correction stage
// that feeds the output register. The register file is a pair of synchronous RAMs
// with registered reads, written together;
// a write from the execute stage is forwarded to the instruction behind it.
// Reset clears all registers, flags, MAC and PC; register file entries read as
// zero until first written, tracked by one valid bit per entry.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling until each holds a request, after which
// s_axis_tready drops. Empty stages are skipped over, so no bubble is held.
`default_nettype none
module risc_integer_execute_unit (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [23:0]  s_axis_tdata,  // cmd[4:0], dest_index[8:5], src_index[12:9], imm8[20:13]
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [135:0] m_axis_tdata   // dest_value[31:0], t_flag[32], next_pc[64:33],
	                                    // mac_high[96:65], mac_low[128:97], cycles_taken[130:129]
);
	import rieu_pkg::*;

	// Request fields.
	logic [4:0]           in_cmd;
	logic [REG_IDX_W-1:0] in_n;
	logic [REG_IDX_W-1:0] in_m;
	logic [7:0]           in_imm;
	logic [REG_IDX_W-1:0] in_a;
	logic                 accept;

	// Stage 1: register file data arrives, instruction executes.
	logic                 valid_s1;
	logic [4:0]           cmd_s1;
	logic [REG_IDX_W-1:0] a_idx_s1;
	logic [REG_IDX_W-1:0] m_idx_s1;
	logic [7:0]           imm_s1;

	// Stage 2: MAC correction.
	logic                 valid_s2;
	logic [XLEN-1:0]      dest_s2;
	logic                 t_s2;
	logic [XLEN-1:0]      pc_s2;
	logic [1:0]           cyc_s2;
	logic [2*XLEN-1:0]    prod_s2;
	logic [XLEN-1:0]      rn_s2;
	logic [XLEN-1:0]      rm_s2;
	mac_ctl_t             mac_ctl_s2;

	// Architectural state held in flops.
	logic                 t_q, q_q, m_q;
	logic [XLEN-1:0]      pc_q, mach_q, macl_q;
	logic [NUM_REGS-1:0]  reg_vld_q;

	// Last register file write, for forwarding into stage 1.
	logic                 fwd_vld_q;
	logic [REG_IDX_W-1:0] fwd_idx_q;
	logic [XLEN-1:0]      fwd_data_q;

	// Output register.
	logic                 out_vld_q;
	logic [XLEN-1:0]      out_dest_q, out_pc_q, out_mach_q, out_macl_q;
	logic                 out_t_q;
	logic [1:0]           out_cyc_q;

	logic                 adv_out, adv_s2, adv_s1;
	logic [XLEN-1:0]      ram_a, ram_b, rn, rm;
	alu_res_t             res;
	logic [2*XLEN-1:0]    prod;
	logic [REG_IDX_W-1:0] wr_idx;
	logic                 wr_en;
	logic [XLEN-1:0]      mach_next, macl_next;

	assign in_cmd = s_axis_tdata[4:0];
	assign in_n   = s_axis_tdata[8:5];
	assign in_m   = s_axis_tdata[12:9];
	assign in_imm = s_axis_tdata[20:13];
	// The immediate AND and compare forms operate on R0 and report it.
	assign in_a   = (in_cmd == CMD_ANDI || in_cmd == CMD_CMPEQI) ? '0 : in_n;

	// Each stage moves when the one ahead of it is empty or moving.
	assign adv_out       = !out_vld_q || m_axis_tready;
	assign adv_s2        = !valid_s2 || adv_out;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign wr_idx = a_idx_s1;
	assign wr_en  = valid_s1 && adv_s2 && res.wr_en;

	rieu_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
		.clk(clk), .we(wr_en), .waddr(wr_idx), .wdata(res.wr_data),
		.re(accept), .raddr(in_a), .rdata(ram_a)
	);

	rieu_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
		.clk(clk), .we(wr_en), .waddr(wr_idx), .wdata(res.wr_data),
		.re(accept), .raddr(in_m), .rdata(ram_b)
	);

	// The RAM read raced the previous instruction's write; take the forwarded
	// value in that case, and zero for an entry never written since reset.
	always_comb begin
		if (fwd_vld_q && fwd_idx_q == a_idx_s1) begin
			rn = fwd_data_q;
		end else begin
			rn = reg_vld_q[a_idx_s1] ? ram_a : '0;
		end
		if (fwd_vld_q && fwd_idx_q == m_idx_s1) begin
			rm = fwd_data_q;
		end else begin
			rm = reg_vld_q[m_idx_s1] ? ram_b : '0;
		end
	end

	rieu_alu u_alu (
		.cmd(cmd_s1), .imm(imm_s1), .rn(rn), .rm(rm),
		.t_in(t_q), .q_in(q_q), .m_in(m_q), .pc(pc_q),
		.res(res), .prod(prod)
	);

	rieu_mac u_mac (
		.ctl(mac_ctl_s2), .prod(prod_s2), .rn(rn_s2), .rm(rm_s2),
		.mach(mach_q), .macl(macl_q),
		.mach_next(mach_next), .macl_next(macl_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			out_vld_q  <= 1'b0;
			t_q        <= 1'b0;
			q_q        <= 1'b0;
			m_q        <= 1'b0;
			pc_q       <= '0;
			mach_q     <= '0;
			macl_q     <= '0;
			reg_vld_q  <= '0;
			fwd_vld_q  <= 1'b0;
			mac_ctl_s2 <= '0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= accept;
			end
			if (accept) begin
				cmd_s1   <= in_cmd;
				a_idx_s1 <= in_a;
				m_idx_s1 <= in_m;
				imm_s1   <= in_imm;
			end

			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && adv_s2) begin
				t_q        <= res.t;
				q_q        <= res.q;
				m_q        <= res.m;
				pc_q       <= res.pc_next;
				dest_s2    <= res.wr_en ? res.wr_data : rn;
				t_s2       <= res.t;
				pc_s2      <= res.pc_next;
				cyc_s2     <= res.cycles;
				prod_s2    <= prod;
				rn_s2      <= rn;
				rm_s2      <= rm;
				mac_ctl_s2 <= '{mul_en: res.mul_en, mul_signed: res.mul_signed,
					clr_mac: res.clr_mac};
			end
			if (wr_en) begin
				reg_vld_q[wr_idx] <= 1'b1;
				fwd_vld_q         <= 1'b1;
				fwd_idx_q         <= wr_idx;
				fwd_data_q        <= res.wr_data;
			end

			if (adv_out) begin
				out_vld_q <= valid_s2;
			end
			if (valid_s2 && adv_out) begin
				mach_q     <= mach_next;
				macl_q     <= macl_next;
				out_dest_q <= dest_s2;
				out_t_q    <= t_s2;
				out_pc_q   <= pc_s2;
				out_mach_q <= mach_next;
				out_macl_q <= macl_next;
				out_cyc_q  <= cyc_s2;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, out_cyc_q, out_macl_q, out_mach_q, out_pc_q, out_t_q,
		out_dest_q};
endmodule
`default_nettype wire

FILE: design/rieu_checker.sv
// Port-level checks for the integer execute unit, bound to its top level.
// Depends on risc_integer_execute_unit.
`default_nettype none
module rieu_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         s_axis_tready,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [135:0] m_axis_tdata
);
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("request refused with empty output");

	a_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[130:129] != 2'd0)
		else $error("zero cycle count");
endmodule

bind risc_integer_execute_unit rieu_checker u_rieu_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
